[rtl/mtk_pkg.sv]
// ----------------------------------------------------------------------------
// mtk_pkg
// Shared constants and helper functions for the multi-tap keypad text entry:
// chord masks, key letter table and tap index advance.
// ----------------------------------------------------------------------------
package mtk_pkg;

  localparam int KEY_COUNT   = 9;
  localparam int TAPS        = 3;
  localparam int KEY_W       = 4;
  localparam int TAP_W       = 2;
  localparam int CHAR_W      = 8;
  localparam int POS_W       = 5;
  localparam int LEN_W       = 6;

  localparam logic [KEY_COUNT-1:0] CHORD_CLEAR = 9'h006;
  localparam logic [KEY_COUNT-1:0] CHORD_MODE  = 9'h030;
  localparam logic [KEY_COUNT-1:0] CHORD_SPACE = 9'h180;

  localparam logic [KEY_W-1:0]  KEY_FIRST  = 4'd1;
  localparam logic [KEY_W-1:0]  KEY_LAST   = 4'd9;
  localparam logic [KEY_W-1:0]  KEY_NONE   = 4'd0;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;

  localparam logic [CHAR_W-1:0] KEY_LETTERS [10][TAPS] = '{
    '{8'h20, 8'h20, 8'h20},
    '{8'h2E, 8'h51, 8'h5A},
    '{8'h41, 8'h42, 8'h43},
    '{8'h44, 8'h45, 8'h46},
    '{8'h47, 8'h48, 8'h49},
    '{8'h4A, 8'h4B, 8'h4C},
    '{8'h4D, 8'h4E, 8'h4F},
    '{8'h50, 8'h52, 8'h53},
    '{8'h54, 8'h55, 8'h56},
    '{8'h57, 8'h58, 8'h59}
  };

  function automatic logic [CHAR_W-1:0] key_letter(input logic [KEY_W-1:0] k,
                                                   input logic [TAP_W-1:0] tap);
    logic [CHAR_W-1:0] c;
    c = SPACE_CHAR;
    if (k <= KEY_LAST && tap < TAP_W'(TAPS)) begin
      c = KEY_LETTERS[k][tap];
    end
    return c;
  endfunction

  // (tap + 1) mod 3
  function automatic logic [TAP_W-1:0] tap_advance(input logic [TAP_W-1:0] tap);
    logic [TAP_W-1:0] t;
    case (tap)
      2'd0:    t = 2'd1;
      2'd1:    t = 2'd2;
      2'd2:    t = 2'd0;
      default: t = 2'd1;
    endcase
    return t;
  endfunction

endpackage

[rtl/mtk_wrap_add.sv]
// ----------------------------------------------------------------------------
// mtk_wrap_add
// Shared ring address unit: y = (a + b) mod MOD, with a < MOD and b <= MOD.
// ----------------------------------------------------------------------------
module mtk_wrap_add #(
  parameter int MOD = 32,
  localparam int AW = $clog2(MOD),
  localparam int CW = $clog2(MOD + 1)
) (
  input  logic [AW-1:0] a,
  input  logic [CW-1:0] b,
  output logic [AW-1:0] y
);

  logic [CW:0] sum;
  logic [CW:0] diff;

  always_comb begin
    sum  = (CW+1)'(a) + (CW+1)'(b);
    diff = sum - (CW+1)'(MOD);
    y    = (sum >= (CW+1)'(MOD)) ? diff[AW-1:0] : sum[AW-1:0];
  end

endmodule

[rtl/mtk_text_ram.sv]
// ----------------------------------------------------------------------------
// mtk_text_ram
// Character ring store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mtk_text_ram #(
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [mtk_pkg::CHAR_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [mtk_pkg::CHAR_W-1:0] rdata
);

  import mtk_pkg::*;

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/multi_tap_keypad_text_entry.sv]
// ----------------------------------------------------------------------------
// multi_tap_keypad_text_entry
// Multi-tap keypad text entry with chords, digit mode and a scrolling line.
// ----------------------------------------------------------------------------
// One key item is taken at a time; keys_ready is low until the whole line for
// that item has been delivered. An item passes through the chord state S_CHORD,
// a nine-step scan of the keys in S_KEYS with at most one text write per step,
// the turnaround state S_LINE, then S_LOAD and S_SHOW for each column, which
// wait on line_ready, through the single read port of the text store. Text is
// kept as a ring, so a full line scrolls by moving its head.
module multi_tap_keypad_text_entry #(
  parameter int LINE_LENGTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        keys_valid,
  output logic                        keys_ready,
  input  logic [mtk_pkg::KEY_COUNT-1:0] keys_pressed,
  output logic                        line_valid,
  input  logic                        line_ready,
  output logic [mtk_pkg::POS_W-1:0]   position,
  output logic [mtk_pkg::CHAR_W-1:0]  display_char,
  output logic [mtk_pkg::LEN_W-1:0]   text_length,
  output logic                        number_mode,
  output logic                        last
);

  import mtk_pkg::*;

  localparam int AW = $clog2(LINE_LENGTH);
  localparam int CW = $clog2(LINE_LENGTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(LINE_LENGTH);
  localparam logic [AW-1:0] LAST_COL   = AW'(LINE_LENGTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CHORD, S_KEYS, S_LINE, S_LOAD, S_SHOW
  } state_t;

  state_t               state;
  logic [KEY_COUNT-1:0] keys;
  logic [KEY_W-1:0]     key_num;
  logic [CW-1:0]        count;
  logic [AW-1:0]        head;
  logic                 digit_mode;
  logic [KEY_W-1:0]     prev_key;
  logic [TAP_W-1:0]     tap;
  logic [AW-1:0]        rd_ptr;
  logic [AW-1:0]        col;

  logic [CW-1:0]        count_eff;
  logic [CW-1:0]        count_next;
  logic [AW-1:0]        head_next;
  logic [KEY_W-1:0]     prev_key_next;
  logic [TAP_W-1:0]     tap_next;
  logic [TAP_W-1:0]     tap_adv;
  logic                 do_write;
  logic                 do_append;
  logic                 full;
  logic [CHAR_W-1:0]    wdata;
  logic [AW-1:0]        unit_a;
  logic [CW-1:0]        unit_b;
  logic [AW-1:0]        unit_y;
  logic [AW-1:0]        head_inc;
  logic [AW-1:0]        rd_addr;
  logic [CHAR_W-1:0]    rd_data;
  logic                 clear_chord;
  logic                 mode_chord;
  logic                 space_chord;
  logic                 out_fire;

  assign clear_chord = (keys & CHORD_CLEAR) == CHORD_CLEAR;
  assign mode_chord  = (keys & CHORD_MODE) == CHORD_MODE;
  assign space_chord = (keys & CHORD_SPACE) == CHORD_SPACE;
  assign out_fire    = line_valid && line_ready;
  assign keys_ready  = (state == S_IDLE);
  assign tap_adv     = tap_advance(tap);
  assign head_inc    = (head == LAST_COL) ? '0 : head + AW'(1);

  always_comb begin
    count_eff     = (state == S_CHORD && clear_chord) ? '0 : count;
    do_write      = 1'b0;
    do_append     = 1'b0;
    wdata         = SPACE_CHAR;
    prev_key_next = prev_key;
    tap_next      = tap;
    if (state == S_CHORD && space_chord) begin
      do_write  = 1'b1;
      do_append = 1'b1;
    end else if (state == S_KEYS && keys[0]) begin
      do_write = 1'b1;
      if (digit_mode) begin
        do_append = 1'b1;
        wdata     = DIGIT_ZERO + CHAR_W'(key_num);
      end else if (prev_key == key_num) begin
        tap_next  = tap_adv;
        do_append = (count == '0);
        wdata     = key_letter(key_num, tap_adv);
      end else begin
        prev_key_next = key_num;
        tap_next      = '0;
        do_append     = 1'b1;
        wdata         = key_letter(key_num, '0);
      end
    end
    full = (count_eff == FULL_COUNT);

    if (state == S_SHOW) begin
      unit_a = rd_ptr;
      unit_b = CW'(1);
    end else begin
      unit_a = head;
      if (do_append) begin
        unit_b = full ? '0 : count_eff;
      end else begin
        unit_b = count_eff - CW'(1);
      end
    end

    count_next = count_eff;
    head_next  = head;
    if (do_write && do_append) begin
      if (full) begin
        head_next = head_inc;
      end else begin
        count_next = count_eff + CW'(1);
      end
    end

    if (state == S_LINE) begin
      rd_addr = head;
    end else if (state == S_SHOW && out_fire) begin
      rd_addr = unit_y;
    end else begin
      rd_addr = rd_ptr;
    end
  end

  mtk_wrap_add #(.MOD(LINE_LENGTH)) u_addr (
    .a(unit_a),
    .b(unit_b),
    .y(unit_y)
  );

  mtk_text_ram #(.DEPTH(LINE_LENGTH)) u_ram (
    .clk  (clk),
    .we   (do_write),
    .waddr(unit_y),
    .wdata(wdata),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      head       <= '0;
      digit_mode <= 1'b0;
      prev_key   <= KEY_NONE;
      tap        <= '0;
      line_valid <= 1'b0;
      keys       <= '0;
      key_num    <= KEY_FIRST;
      rd_ptr     <= '0;
      col        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (keys_valid) begin
            keys  <= keys_pressed;
            state <= S_CHORD;
          end
        end
        S_CHORD: begin
          count      <= count_next;
          head       <= head_next;
          digit_mode <= digit_mode ^ mode_chord;
          keys       <= keys & ~((clear_chord ? CHORD_CLEAR : '0) |
                                 (mode_chord  ? CHORD_MODE  : '0) |
                                 (space_chord ? CHORD_SPACE : '0));
          key_num    <= KEY_FIRST;
          state      <= S_KEYS;
        end
        S_KEYS: begin
          count    <= count_next;
          head     <= head_next;
          prev_key <= prev_key_next;
          tap      <= tap_next;
          keys     <= keys >> 1;
          key_num  <= key_num + KEY_W'(1);
          if (key_num == KEY_LAST) begin
            state <= S_LINE;
          end
        end
        S_LINE: begin
          rd_ptr <= head;
          col    <= '0;
          state  <= S_LOAD;
        end
        S_LOAD: begin
          line_valid   <= 1'b1;
          position     <= POS_W'(col);
          display_char <= (CW'(col) < count) ? rd_data : SPACE_CHAR;
          text_length  <= LEN_W'(count);
          number_mode  <= digit_mode;
          last         <= (col == LAST_COL);
          state        <= S_SHOW;
        end
        S_SHOW: begin
          if (out_fire) begin
            line_valid <= 1'b0;
            rd_ptr     <= unit_y;
            col        <= col + AW'(1);
            state      <= last ? S_IDLE : S_LOAD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_not_both: assert property (@(posedge clk) disable iff (rst)
    !(keys_ready && line_valid))
    else $error("input taken while a line item is pending");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("character count above line length");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (line_valid && line_ready && last) |=> keys_ready)
    else $error("not ready after final column");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (keys_valid && keys_ready) |=> !keys_ready && !line_valid)
    else $error("sequencer did not start after accepted item");

endmodule
